// ----- rtl/core/wop_pkg.sv -----
// wop_pkg: types, constants and the arctangent table for the wheel odometry core
// shared by wop_mul, wop_cordic and wheel_odometry_pose; no dependencies
`timescale 1ns / 1ps

package wop_pkg;

    typedef struct packed {
        logic [31:0]        sample_time;
        logic signed [31:0] front_left_count;
        logic signed [31:0] front_right_count;
        logic signed [31:0] back_left_count;
        logic signed [31:0] back_right_count;
    } in_word_t;

    typedef struct packed {
        logic [31:0]        pose_time;
        logic signed [47:0] pos_x;
        logic signed [47:0] pos_y;
        logic signed [31:0] heading;
    } out_word_t;

    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] REG_METERS_PER_TICK   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_INVERSE_WHEELBASE = 2'd1;
    localparam logic [31:0] MPT_RESET = 32'd7906076;
    localparam logic [31:0] IWB_RESET = 32'd16777216;

    localparam int MUL_A_W = 57;
    localparam int MUL_B_W = 32;
    localparam int MUL_P_W = MUL_A_W + MUL_B_W;

    typedef struct packed {
        logic               start;
        logic [MUL_A_W-1:0] a;
        logic [MUL_B_W-1:0] b;
    } mul_req_t;

    typedef struct packed {
        logic               done;
        logic [MUL_P_W-1:0] prod;
    } mul_rsp_t;

    localparam int ANG_W = 48;
    localparam int RED_W = 47;
    localparam int ROT_W = 34;
    localparam int RED_STEPS = 13;
    localparam logic [RED_W-1:0] TWO_PI_RED = 47'd6746518852;
    localparam logic [RED_W-1:0] RED_TOP = TWO_PI_RED << (RED_STEPS - 1);
    localparam logic signed [ROT_W-1:0] PI_Q30      = 34'sd3373259426;
    localparam logic signed [ROT_W-1:0] HALF_PI_Q30 = 34'sd1686629713;
    localparam logic signed [ROT_W-1:0] TWO_PI_Q30  = 34'sd6746518852;
    localparam logic signed [ROT_W-1:0] GAIN_Q30    = 34'sd652032874;

    localparam logic [64:0] DTH_CAP = 65'd1 << 40;

    typedef enum logic [1:0] {
        COR_IDLE,
        COR_REDUCE,
        COR_FOLD,
        COR_ROTATE
    } cor_state_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DIST_GO,
        ST_DIST_WT,
        ST_DIFF_GO,
        ST_DIFF_WT,
        ST_DTH_GO,
        ST_DTH_WT,
        ST_ROT_GO,
        ST_ROT_WT,
        ST_MX_GO,
        ST_MX_WT,
        ST_MY_GO,
        ST_MY_WT,
        ST_DONE
    } odo_state_t;

    function automatic logic signed [ROT_W-1:0] atan_q30(input logic [4:0] i);
        logic signed [ROT_W-1:0] v;
        case (i)
            5'd0:    v = 34'sh03243F6A8;
            5'd1:    v = 34'sh01DAC6705;
            5'd2:    v = 34'sh00FADBAFC;
            5'd3:    v = 34'sh007F56EA6;
            5'd4:    v = 34'sh003FEAB76;
            5'd5:    v = 34'sh001FFD55B;
            5'd6:    v = 34'sh000FFFAAA;
            5'd7:    v = 34'sh0007FFF55;
            5'd8:    v = 34'sh0003FFFEA;
            5'd9:    v = 34'sh0001FFFFD;
            5'd10:   v = 34'sd1048575;
            5'd11:   v = 34'sd524287;
            5'd12:   v = 34'sd262143;
            5'd13:   v = 34'sd131071;
            5'd14:   v = 34'sd65535;
            5'd15:   v = 34'sd32767;
            5'd16:   v = 34'sd16383;
            5'd17:   v = 34'sd8191;
            5'd18:   v = 34'sd4095;
            5'd19:   v = 34'sd2047;
            5'd20:   v = 34'sd1023;
            5'd21:   v = 34'sd511;
            5'd22:   v = 34'sd255;
            5'd23:   v = 34'sd127;
            5'd24:   v = 34'sd63;
            5'd25:   v = 34'sd31;
            5'd26:   v = 34'sd15;
            5'd27:   v = 34'sd7;
            5'd28:   v = 34'sd3;
            5'd29:   v = 34'sd1;
            default: v = 34'sd0;
        endcase
        return v;
    endfunction

endpackage

// ----- rtl/core/wop_mul.sv -----
// wop_mul: bit-serial unsigned shift-add multiplier, one multiplier bit per cycle
// depends on wop_pkg (request/response structs, operand widths)
`timescale 1ns / 1ps

module wop_mul (
    input  logic              aclk,
    input  logic              aresetn,
    input  wop_pkg::mul_req_t req,
    output wop_pkg::mul_rsp_t rsp
);

    localparam int CNT_W = $clog2(wop_pkg::MUL_B_W);

    logic                         busy_reg;
    logic                         done_reg;
    logic [CNT_W-1:0]             cnt_reg;
    logic [wop_pkg::MUL_A_W-1:0]  a_reg;
    logic [wop_pkg::MUL_A_W:0]    hi_reg;
    logic [wop_pkg::MUL_B_W-1:0]  lo_reg;
    logic [wop_pkg::MUL_A_W:0]    sum;
    logic                         last;

    assign sum  = hi_reg + (lo_reg[0] ? {1'b0, a_reg} : '0);
    assign last = (cnt_reg == CNT_W'(wop_pkg::MUL_B_W - 1));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= busy_reg && last;
            if (req.start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 1'b1;
                if (last) begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (req.start) begin
            a_reg  <= req.a;
            hi_reg <= '0;
            lo_reg <= req.b;
        end else if (busy_reg) begin
            hi_reg <= sum >> 1;
            lo_reg <= {sum[0], lo_reg[wop_pkg::MUL_B_W-1:1]};
        end
    end

    assign rsp.done = done_reg;
    assign rsp.prod = wop_pkg::MUL_P_W'({hi_reg, lo_reg});

endmodule

// ----- rtl/core/wop_cordic.sv -----
// wop_cordic: angle reduction by shift-subtract, quadrant fold, iterative CORDIC rotation
// depends on wop_pkg (angle constants, arctangent table, state type)
`timescale 1ns / 1ps

module wop_cordic #(
    parameter int CORDIC_STEPS = 24
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               start,
    input  logic signed [wop_pkg::ANG_W-1:0]   ang,
    output logic                               done,
    output logic signed [wop_pkg::ROT_W-1:0]   cos_out,
    output logic signed [wop_pkg::ROT_W-1:0]   sin_out
);

    localparam int CNT_W = $clog2(CORDIC_STEPS);
    localparam int RW = wop_pkg::ROT_W;

    wop_pkg::cor_state_t state_reg, state_next;

    logic [CNT_W-1:0]               cnt_reg;
    logic                           done_reg;
    logic                           sgn_reg;
    logic                           flip_reg;
    logic [wop_pkg::RED_W-1:0]      m_reg;
    logic [wop_pkg::RED_W-1:0]      t_reg;
    logic signed [RW-1:0]           r_reg;
    logic signed [RW-1:0]           x_reg;
    logic signed [RW-1:0]           y_reg;

    logic                           red_last;
    logic                           rot_last;
    logic                           red_en;
    logic                           fold_en;
    logic                           rot_en;
    logic signed [RW-1:0]           r0;
    logic signed [RW-1:0]           r1;
    logic signed [RW-1:0]           r2;
    logic                           flip;
    logic signed [RW-1:0]           dx;
    logic signed [RW-1:0]           dy;
    logic signed [RW-1:0]           at;
    logic [wop_pkg::RED_W-1:0]      ang_mag;

    assign red_last = (cnt_reg == CNT_W'(wop_pkg::RED_STEPS - 1));
    assign rot_last = (cnt_reg == CNT_W'(CORDIC_STEPS - 1));

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            wop_pkg::COR_IDLE: begin
                if (start) begin
                    state_next = wop_pkg::COR_REDUCE;
                end
            end
            wop_pkg::COR_REDUCE: begin
                if (red_last) begin
                    state_next = wop_pkg::COR_FOLD;
                end
            end
            wop_pkg::COR_FOLD: begin
                state_next = wop_pkg::COR_ROTATE;
            end
            wop_pkg::COR_ROTATE: begin
                if (rot_last) begin
                    state_next = wop_pkg::COR_IDLE;
                end
            end
            default: state_next = wop_pkg::COR_IDLE;
        endcase
    end

    always_comb begin
        red_en  = 1'b0;
        fold_en = 1'b0;
        rot_en  = 1'b0;
        unique case (state_reg)
            wop_pkg::COR_IDLE:   ;
            wop_pkg::COR_REDUCE: red_en  = 1'b1;
            wop_pkg::COR_FOLD:   fold_en = 1'b1;
            wop_pkg::COR_ROTATE: rot_en  = 1'b1;
            default:             ;
        endcase
    end

    assign ang_mag = ang[wop_pkg::ANG_W-1] ? wop_pkg::RED_W'(-ang) : wop_pkg::RED_W'(ang);

    // remainder keeps the sign of the angle, then fold into half turn and quarter turn
    always_comb begin
        r0 = sgn_reg ? -$signed(RW'(m_reg)) : $signed(RW'(m_reg));
        if (r0 > wop_pkg::PI_Q30) begin
            r1 = r0 - wop_pkg::TWO_PI_Q30;
        end else if (r0 < -wop_pkg::PI_Q30) begin
            r1 = r0 + wop_pkg::TWO_PI_Q30;
        end else begin
            r1 = r0;
        end
        flip = 1'b0;
        if (r1 > wop_pkg::HALF_PI_Q30) begin
            r2   = r1 - wop_pkg::PI_Q30;
            flip = 1'b1;
        end else if (r1 < -wop_pkg::HALF_PI_Q30) begin
            r2   = r1 + wop_pkg::PI_Q30;
            flip = 1'b1;
        end else begin
            r2 = r1;
        end
    end

    assign dx = y_reg >>> cnt_reg;
    assign dy = x_reg >>> cnt_reg;
    assign at = wop_pkg::atan_q30(5'(cnt_reg));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= wop_pkg::COR_IDLE;
            cnt_reg   <= '0;
            done_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            done_reg  <= rot_en && rot_last;
            if (start || fold_en || (red_en && red_last)) begin
                cnt_reg <= '0;
            end else if (red_en || rot_en) begin
                cnt_reg <= cnt_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            m_reg   <= ang_mag;
            t_reg   <= wop_pkg::RED_TOP;
            sgn_reg <= ang[wop_pkg::ANG_W-1];
        end else if (red_en) begin
            if (m_reg >= t_reg) begin
                m_reg <= m_reg - t_reg;
            end
            t_reg <= t_reg >> 1;
        end
        if (fold_en) begin
            r_reg    <= r2;
            flip_reg <= flip;
            x_reg    <= wop_pkg::GAIN_Q30;
            y_reg    <= '0;
        end else if (rot_en) begin
            if (!r_reg[RW-1]) begin
                x_reg <= x_reg - dx;
                y_reg <= y_reg + dy;
                r_reg <= r_reg - at;
            end else begin
                x_reg <= x_reg + dx;
                y_reg <= y_reg - dy;
                r_reg <= r_reg + at;
            end
        end
    end

    assign done    = done_reg;
    assign cos_out = flip_reg ? -x_reg : x_reg;
    assign sin_out = flip_reg ? -y_reg : y_reg;

    assert property (@(posedge aclk) disable iff (!aresetn)
        done_reg |-> state_reg == wop_pkg::COR_IDLE)
        else $error("cordic done outside idle");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (red_en && red_last) |=> state_reg == wop_pkg::COR_FOLD && cnt_reg == '0)
        else $error("reduction did not hand over to fold");

    assert property (@(posedge aclk) disable iff (!aresetn)
        fold_en |=> m_reg < wop_pkg::TWO_PI_RED)
        else $error("angle not reduced below full turn");

endmodule

// ----- rtl/core/wheel_odometry_pose.sv -----
// wheel_odometry_pose: differential drive odometry, shared serial multiplier and CORDIC
// depends on wop_pkg, wop_mul, wop_cordic
`timescale 1ns / 1ps
//
//  channel  ports                         word        direction
//  sample   s_valid s_ready s_data        in_word_t   in
//  pose     m_valid m_ready m_data        out_word_t  out
//  config   cfg_we cfg_index cfg_data     32 bits     in, write only
//
//  first sample after reset gives no pose
//  from accept to ready, each later sample runs three products on the bit-serial
//  multiplier (distance, difference, heading step), then the CORDIC unit
//  (13 reduction steps, one fold, CORDIC_STEPS rotations), then two more products
//  (x and y steps), and then waits until the output register is free
//  synchronous active-low reset resets pose, counts and config registers to defaults
//  a pose waits in the output register; the next sample is taken once it is loaded
//
module wheel_odometry_pose #(
    parameter int CORDIC_STEPS = 24,
    parameter int COUNT_BITS   = 32
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  wop_pkg::in_word_t                 s_data,
    output logic                              m_valid,
    input  logic                              m_ready,
    output wop_pkg::out_word_t                m_data,
    input  logic                              cfg_we,
    input  logic [wop_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [31:0]                       cfg_data
);

    wop_pkg::odo_state_t state_reg, state_next;

    logic [31:0]               mpt_reg;
    logic [31:0]               iwb_reg;
    logic                      seen_first_reg;
    logic [31:0]               last_reg [4];
    logic signed [47:0]        acc_x_reg;
    logic signed [47:0]        acc_y_reg;
    logic signed [31:0]        acc_h_reg;
    logic                      m_valid_reg;
    wop_pkg::out_word_t        out_reg;
    logic [31:0]               time_reg;
    logic signed [33:0]        sum_l_reg;
    logic signed [33:0]        sum_r_reg;
    logic [55:0]               dist_mag_reg;
    logic                      dist_neg_reg;
    logic [56:0]               diff_mag_reg;
    logic                      diff_neg_reg;
    logic [40:0]               dth_mag_reg;

    wop_pkg::mul_req_t         mul_req;
    wop_pkg::mul_rsp_t         mul_rsp;
    logic                      cor_start;
    logic                      cor_done;
    logic signed [wop_pkg::ROT_W-1:0] cos_v;
    logic signed [wop_pkg::ROT_W-1:0] sin_v;

    logic                      accept;
    logic [31:0]               cur [4];
    logic signed [COUNT_BITS-1:0] dlow [4];
    logic signed [33:0]        dt [4];
    logic signed [34:0]        tot;
    logic signed [34:0]        dif;
    logic [34:0]               tot_mag;
    logic [34:0]               dif_mag;
    logic [64:0]               p24;
    logic signed [41:0]        dth_s;
    logic signed [41:0]        half_s;
    logic signed [41:0]        mid;
    logic signed [wop_pkg::ANG_W-1:0] ang;
    logic [31:0]               cos_mag;
    logic [31:0]               sin_mag;
    logic [57:0]               step_mag;
    logic signed [58:0]        step_s;
    logic signed [59:0]        pos_sum;
    logic signed [47:0]        pos_sat;
    logic                      trig_neg;
    logic signed [42:0]        h_sum;
    logic signed [31:0]        h_sat;
    logic                      out_free;

    assign accept   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;

    assign cur[0] = s_data.front_left_count;
    assign cur[1] = s_data.front_right_count;
    assign cur[2] = s_data.back_left_count;
    assign cur[3] = s_data.back_right_count;

    always_comb begin
        for (int k = 0; k < 4; k++) begin
            dlow[k] = COUNT_BITS'(cur[k] - last_reg[k]);
            dt[k]   = 34'(dlow[k]);
        end
    end

    assign tot     = 35'(sum_l_reg) + 35'(sum_r_reg);
    assign dif     = 35'(sum_r_reg) - 35'(sum_l_reg);
    assign tot_mag = tot[34] ? 35'(-tot) : 35'(tot);
    assign dif_mag = dif[34] ? 35'(-dif) : 35'(dif);

    assign p24 = 65'(mul_rsp.prod >> 24);

    assign dth_s  = diff_neg_reg ? -$signed({1'b0, dth_mag_reg}) : $signed({1'b0, dth_mag_reg});
    assign half_s = diff_neg_reg ? -$signed({2'b00, dth_mag_reg[40:1]})
                                 : $signed({2'b00, dth_mag_reg[40:1]});
    assign mid    = 42'(acc_h_reg) + half_s;
    assign ang    = {mid, 6'b000000};

    assign cos_mag = cos_v[wop_pkg::ROT_W-1] ? 32'(-cos_v) : 32'(cos_v);
    assign sin_mag = sin_v[wop_pkg::ROT_W-1] ? 32'(-sin_v) : 32'(sin_v);

    // position step: sign of distance times sign of cos or sin, magnitude product >> 30
    always_comb begin
        step_mag = 58'(mul_rsp.prod >> 30);
        trig_neg = (state_reg == wop_pkg::ST_MX_WT) ? cos_v[wop_pkg::ROT_W-1]
                                                     : sin_v[wop_pkg::ROT_W-1];
        step_s   = (dist_neg_reg ^ trig_neg) ? -$signed({1'b0, step_mag})
                                             : $signed({1'b0, step_mag});
        pos_sum  = (state_reg == wop_pkg::ST_MX_WT) ? 60'(acc_x_reg) + 60'(step_s)
                                                     : 60'(acc_y_reg) + 60'(step_s);
        if (pos_sum > 60'sh7FFFFFFFFFFF) begin
            pos_sat = 48'sh7FFFFFFFFFFF;
        end else if (pos_sum < -60'sh800000000000) begin
            pos_sat = -48'sh800000000000;
        end else begin
            pos_sat = 48'(pos_sum);
        end
        h_sum = 43'(acc_h_reg) + 43'(dth_s);
        if (h_sum > 43'sh7FFFFFFF) begin
            h_sat = 32'sh7FFFFFFF;
        end else if (h_sum < -43'sh80000000) begin
            h_sat = -32'sh80000000;
        end else begin
            h_sat = 32'(h_sum);
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            wop_pkg::ST_IDLE: begin
                if (accept && seen_first_reg) begin
                    state_next = wop_pkg::ST_DIST_GO;
                end
            end
            wop_pkg::ST_DIST_GO: state_next = wop_pkg::ST_DIST_WT;
            wop_pkg::ST_DIST_WT: begin
                if (mul_rsp.done) begin
                    state_next = wop_pkg::ST_DIFF_GO;
                end
            end
            wop_pkg::ST_DIFF_GO: state_next = wop_pkg::ST_DIFF_WT;
            wop_pkg::ST_DIFF_WT: begin
                if (mul_rsp.done) begin
                    state_next = wop_pkg::ST_DTH_GO;
                end
            end
            wop_pkg::ST_DTH_GO: state_next = wop_pkg::ST_DTH_WT;
            wop_pkg::ST_DTH_WT: begin
                if (mul_rsp.done) begin
                    state_next = wop_pkg::ST_ROT_GO;
                end
            end
            wop_pkg::ST_ROT_GO: state_next = wop_pkg::ST_ROT_WT;
            wop_pkg::ST_ROT_WT: begin
                if (cor_done) begin
                    state_next = wop_pkg::ST_MX_GO;
                end
            end
            wop_pkg::ST_MX_GO: state_next = wop_pkg::ST_MX_WT;
            wop_pkg::ST_MX_WT: begin
                if (mul_rsp.done) begin
                    state_next = wop_pkg::ST_MY_GO;
                end
            end
            wop_pkg::ST_MY_GO: state_next = wop_pkg::ST_MY_WT;
            wop_pkg::ST_MY_WT: begin
                if (mul_rsp.done) begin
                    state_next = wop_pkg::ST_DONE;
                end
            end
            wop_pkg::ST_DONE: begin
                if (out_free) begin
                    state_next = wop_pkg::ST_IDLE;
                end
            end
            default: state_next = wop_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        s_ready       = 1'b0;
        cor_start     = 1'b0;
        mul_req.start = 1'b0;
        mul_req.a     = '0;
        mul_req.b     = '0;
        unique case (state_reg)
            wop_pkg::ST_IDLE:    s_ready = 1'b1;
            wop_pkg::ST_DIST_GO: begin
                mul_req.start = 1'b1;
                mul_req.a     = wop_pkg::MUL_A_W'(tot_mag);
                mul_req.b     = mpt_reg;
            end
            wop_pkg::ST_DIFF_GO: begin
                mul_req.start = 1'b1;
                mul_req.a     = wop_pkg::MUL_A_W'(dif_mag);
                mul_req.b     = mpt_reg;
            end
            wop_pkg::ST_DTH_GO: begin
                mul_req.start = 1'b1;
                mul_req.a     = diff_mag_reg;
                mul_req.b     = iwb_reg;
            end
            wop_pkg::ST_ROT_GO:  cor_start = 1'b1;
            wop_pkg::ST_MX_GO: begin
                mul_req.start = 1'b1;
                mul_req.a     = wop_pkg::MUL_A_W'(dist_mag_reg);
                mul_req.b     = cos_mag;
            end
            wop_pkg::ST_MY_GO: begin
                mul_req.start = 1'b1;
                mul_req.a     = wop_pkg::MUL_A_W'(dist_mag_reg);
                mul_req.b     = sin_mag;
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= wop_pkg::ST_IDLE;
            mpt_reg        <= wop_pkg::MPT_RESET;
            iwb_reg        <= wop_pkg::IWB_RESET;
            seen_first_reg <= 1'b0;
            acc_x_reg      <= '0;
            acc_y_reg      <= '0;
            acc_h_reg      <= '0;
            m_valid_reg    <= 1'b0;
            for (int k = 0; k < 4; k++) begin
                last_reg[k] <= '0;
            end
        end else begin
            state_reg <= state_next;
            if (cfg_we) begin
                unique case (cfg_index)
                    wop_pkg::REG_METERS_PER_TICK:   mpt_reg <= cfg_data;
                    wop_pkg::REG_INVERSE_WHEELBASE: iwb_reg <= cfg_data;
                    default: ;
                endcase
            end
            if (accept) begin
                seen_first_reg <= 1'b1;
                for (int k = 0; k < 4; k++) begin
                    last_reg[k] <= cur[k];
                end
            end
            if (state_reg == wop_pkg::ST_MX_WT && mul_rsp.done) begin
                acc_x_reg <= pos_sat;
            end
            if (state_reg == wop_pkg::ST_MY_WT && mul_rsp.done) begin
                acc_y_reg <= pos_sat;
                acc_h_reg <= h_sat;
            end
            if (state_reg == wop_pkg::ST_DONE && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            time_reg  <= s_data.sample_time;
            sum_l_reg <= dt[0] + dt[2];
            sum_r_reg <= dt[1] + dt[3];
        end
        if (state_reg == wop_pkg::ST_DIST_WT && mul_rsp.done) begin
            dist_mag_reg <= 56'(mul_rsp.prod >> 10);
            dist_neg_reg <= tot[34];
        end
        if (state_reg == wop_pkg::ST_DIFF_WT && mul_rsp.done) begin
            diff_mag_reg <= 57'(mul_rsp.prod >> 9);
            diff_neg_reg <= dif[34];
        end
        if (state_reg == wop_pkg::ST_DTH_WT && mul_rsp.done) begin
            dth_mag_reg <= (p24 > wop_pkg::DTH_CAP) ? 41'(wop_pkg::DTH_CAP) : 41'(p24);
        end
        if (state_reg == wop_pkg::ST_DONE && out_free) begin
            out_reg.pose_time <= time_reg;
            out_reg.pos_x     <= acc_x_reg;
            out_reg.pos_y     <= acc_y_reg;
            out_reg.heading   <= acc_h_reg;
        end
    end

    wop_mul u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (mul_req),
        .rsp     (mul_rsp)
    );

    wop_cordic #(
        .CORDIC_STEPS (CORDIC_STEPS)
    ) u_cordic (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (cor_start),
        .ang     (ang),
        .done    (cor_done),
        .cos_out (cos_v),
        .sin_out (sin_v)
    );

    assign m_valid = m_valid_reg;
    assign m_data  = out_reg;

    assert property (@(posedge aclk) disable iff (!aresetn)
        mul_rsp.done |-> (state_reg == wop_pkg::ST_DIST_WT || state_reg == wop_pkg::ST_DIFF_WT ||
                          state_reg == wop_pkg::ST_DTH_WT || state_reg == wop_pkg::ST_MX_WT ||
                          state_reg == wop_pkg::ST_MY_WT))
        else $error("product returned while no product was awaited");

    assert property (@(posedge aclk) disable iff (!aresetn)
        cor_done |-> state_reg == wop_pkg::ST_ROT_WT)
        else $error("rotation finished outside its wait state");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && !seen_first_reg) |=> state_reg == wop_pkg::ST_IDLE && !$rose(m_valid_reg))
        else $error("first sample started a pose");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_ready && state_reg != wop_pkg::ST_DONE) |=> !m_valid_reg)
        else $error("pose word repeated");

endmodule
